/* hdl/fse_pkg.sv */
`timescale 1ns / 1ps

package fse_pkg;

    // Fixed field widths
    localparam int DATA_W      = 32;
    localparam int FIELD_IDX_W = 10;
    localparam int CNT_W       = 11;
    localparam int PROBE_W     = 11;
    localparam int FIB_W       = 12;
    localparam int CFG_ADDR_W  = 3;

    // Item opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Register indexes (word index taken from paddr[2])
    localparam logic REG_ELEMENT_COUNT = 1'b0;

    // Table access request from the sequencer
    typedef struct packed {
        logic                   rd_en;
        logic [PROBE_W-1:0]     rd_idx;
        logic                   wr_en;
        logic [FIELD_IDX_W-1:0] wr_idx;
        logic [DATA_W-1:0]      wr_data;
    } t_mem_req;

endpackage

/* hdl/fse_if.sv */
`timescale 1ns / 1ps

interface fse_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic [fse_pkg::FIELD_IDX_W-1:0]      entry_index;
    logic signed [fse_pkg::DATA_W-1:0]    entry_value;
    logic signed [fse_pkg::DATA_W-1:0]    search_key;

    modport source (output valid, opcode, entry_index, entry_value, search_key, input ready);
    modport sink   (input valid, opcode, entry_index, entry_value, search_key, output ready);
endinterface

interface fse_out_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [fse_pkg::FIELD_IDX_W-1:0] match_index;

    modport source (output valid, found, match_index, input ready);
    modport sink   (input valid, found, match_index, output ready);
endinterface

/* hdl/fse_cfg_apb.sv */
`timescale 1ns / 1ps

module fse_cfg_apb (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fse_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [fse_pkg::CNT_W-1:0]       o_element_count
);

    logic [fse_pkg::CNT_W-1:0] r_count;
    logic                      reg_sel;

    assign reg_sel = (paddr[2] == fse_pkg::REG_ELEMENT_COUNT);

    // Write element count on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_count <= pwdata[fse_pkg::CNT_W-1:0];
        end
    end

    // Read back the register, zero elsewhere
    assign prdata          = reg_sel ? {{(32-fse_pkg::CNT_W){1'b0}}, r_count} : 32'd0;
    assign pready          = 1'b1;
    assign o_element_count = r_count;

endmodule

/* hdl/fse_table_mem.sv */
`timescale 1ns / 1ps

module fse_table_mem #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  fse_pkg::t_mem_req                i_mem_req,
    output logic signed [fse_pkg::DATA_W-1:0] o_rdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [fse_pkg::DATA_W-1:0] mem [TABLE_DEPTH];
    logic [fse_pkg::DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_mem_req.wr_en) begin
            mem[AW'(i_mem_req.wr_idx)] <= i_mem_req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_mem_req.rd_en) begin
            r_rdata <= mem[AW'(i_mem_req.rd_idx)];
        end
    end

    assign o_rdata = signed'(r_rdata);

endmodule

/* hdl/fse_search_ctrl.sv */
`timescale 1ns / 1ps

module fse_search_ctrl #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    fse_in_if.sink                             i_in,
    fse_out_if.source                          o_out,
    input  logic [fse_pkg::CNT_W-1:0]          i_element_count,
    input  logic signed [fse_pkg::DATA_W-1:0]  i_rdata,
    output fse_pkg::t_mem_req                  o_mem_req
);

    localparam int CNT_MAX = (TABLE_DEPTH < 2047) ? TABLE_DEPTH : 2047;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_GROW  = 5'b00010,
        ST_PROBE = 5'b00100,
        ST_LAST  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state                              r_state, n_state;
    logic [fse_pkg::FIB_W-1:0]           r_small, n_small;
    logic [fse_pkg::FIB_W-1:0]           r_mid, n_mid;
    logic [fse_pkg::FIB_W-1:0]           r_large, n_large;
    logic signed [fse_pkg::FIB_W-1:0]    r_base, n_base;
    logic [fse_pkg::PROBE_W-1:0]         r_idx, n_idx;
    logic [fse_pkg::CNT_W-1:0]           r_n, n_n;
    logic signed [fse_pkg::DATA_W-1:0]   r_key, n_key;
    logic                                r_found, n_found;
    logic [fse_pkg::PROBE_W-1:0]         r_where, n_where;
    logic                                r_out_valid, n_out_valid;
    logic                                r_out_found, n_out_found;
    logic [fse_pkg::FIELD_IDX_W-1:0]     r_out_idx, n_out_idx;

    logic                                in_accept;
    logic [fse_pkg::CNT_W-1:0]           sat_count;
    logic [fse_pkg::FIB_W-1:0]           p_small, p_mid, p_large;
    logic signed [fse_pkg::FIB_W-1:0]    p_base;

    // Probe position: min(base + small, n - 1)
    function automatic logic [fse_pkg::PROBE_W-1:0] probe_idx(
        input logic signed [fse_pkg::FIB_W-1:0] base,
        input logic [fse_pkg::FIB_W-1:0]        small_fib,
        input logic [fse_pkg::CNT_W-1:0]        n
    );
        logic signed [fse_pkg::FIB_W:0] cand;
        logic signed [fse_pkg::FIB_W:0] last;
        cand = {base[fse_pkg::FIB_W-1], base} + signed'({1'b0, small_fib});
        last = signed'({2'b00, n}) - 13'sd1;
        return (cand < last) ? cand[fse_pkg::PROBE_W-1:0] : last[fse_pkg::PROBE_W-1:0];
    endfunction

    // Pending element after the base still to check
    function automatic logic last_ok(
        input logic [fse_pkg::FIB_W-1:0]        mid,
        input logic signed [fse_pkg::FIB_W-1:0] base,
        input logic [fse_pkg::CNT_W-1:0]        n
    );
        logic signed [fse_pkg::FIB_W:0] nxt;
        nxt = {base[fse_pkg::FIB_W-1], base} + 13'sd1;
        return (mid == 12'd1) && (nxt < signed'({2'b00, n}));
    endfunction

    // Index of the element just after the base
    function automatic logic [fse_pkg::PROBE_W-1:0] PROBE_W_CAST(
        input logic signed [fse_pkg::FIB_W-1:0] base
    );
        logic signed [fse_pkg::FIB_W-1:0] nxt;
        nxt = base + 12'sd1;
        return nxt[fse_pkg::PROBE_W-1:0];
    endfunction

    assign in_accept = i_in.valid && i_in.ready;
    assign sat_count = (32'(i_element_count) > CNT_MAX) ?
                       fse_pkg::CNT_W'(CNT_MAX) : i_element_count;

    // Next Fibonacci triple after a probe compare
    always_comb begin
        if (i_rdata < r_key) begin
            p_base  = signed'({1'b0, r_idx});
            p_large = r_mid;
            p_mid   = r_small;
            p_small = r_mid - r_small;
        end else begin
            p_base  = r_base;
            p_large = r_small;
            p_mid   = r_mid - r_small;
            p_small = r_small - (r_mid - r_small);
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_small     = r_small;
        n_mid       = r_mid;
        n_large     = r_large;
        n_base      = r_base;
        n_idx       = r_idx;
        n_n         = r_n;
        n_key       = r_key;
        n_found     = r_found;
        n_where     = r_where;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_found = r_out_found;
        n_out_idx   = r_out_idx;
        o_mem_req   = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_in.opcode == fse_pkg::OP_WRITE) begin
                        o_mem_req.wr_en   = (32'(i_in.entry_index) < TABLE_DEPTH);
                        o_mem_req.wr_idx  = i_in.entry_index;
                        o_mem_req.wr_data = i_in.entry_value;
                    end else begin
                        n_key   = i_in.search_key;
                        n_n     = sat_count;
                        n_small = 12'd0;
                        n_mid   = 12'd1;
                        n_large = 12'd1;
                        n_base  = -12'sd1;
                        n_found = 1'b0;
                        n_where = '0;
                        n_state = (sat_count == '0) ? ST_DONE : ST_GROW;
                    end
                end
            end
            ST_GROW: begin
                if ({1'b0, r_n} > r_large) begin
                    n_small = r_mid;
                    n_mid   = r_large;
                    n_large = r_large + r_mid;
                end else if (r_large > 12'd1) begin
                    n_idx            = probe_idx(r_base, r_small, r_n);
                    o_mem_req.rd_en  = 1'b1;
                    o_mem_req.rd_idx = n_idx;
                    n_state          = ST_PROBE;
                end else if (last_ok(r_mid, r_base, r_n)) begin
                    n_idx            = PROBE_W_CAST(r_base);
                    o_mem_req.rd_en  = 1'b1;
                    o_mem_req.rd_idx = n_idx;
                    n_state          = ST_LAST;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_PROBE: begin
                if (i_rdata == r_key) begin
                    n_found = 1'b1;
                    n_where = r_idx;
                    n_state = ST_DONE;
                end else begin
                    n_small = p_small;
                    n_mid   = p_mid;
                    n_large = p_large;
                    n_base  = p_base;
                    if (p_large > 12'd1) begin
                        n_idx            = probe_idx(p_base, p_small, r_n);
                        o_mem_req.rd_en  = 1'b1;
                        o_mem_req.rd_idx = n_idx;
                    end else if (last_ok(p_mid, p_base, r_n)) begin
                        n_idx            = PROBE_W_CAST(p_base);
                        o_mem_req.rd_en  = 1'b1;
                        o_mem_req.rd_idx = n_idx;
                        n_state          = ST_LAST;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_LAST: begin
                n_found = (i_rdata == r_key);
                n_where = (i_rdata == r_key) ? r_idx : '0;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_idx   = r_where[fse_pkg::FIELD_IDX_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_small     <= '0;
            r_mid       <= '0;
            r_large     <= '0;
            r_base      <= -12'sd1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_small     <= n_small;
            r_mid       <= n_mid;
            r_large     <= n_large;
            r_base      <= n_base;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_n         <= n_n;
        r_key       <= n_key;
        r_found     <= n_found;
        r_where     <= n_where;
        r_out_found <= n_out_found;
        r_out_idx   <= n_out_idx;
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.match_index = r_out_idx;

    // Table reads stay inside the active count
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.rd_en |-> ({1'b0, o_mem_req.rd_idx} < {1'b0, r_n}))
        else $error("table read past element count");

    // Probing only runs while the largest number exceeds one
    a_probe_large: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> (r_large > 12'd1))
        else $error("probe with exhausted Fibonacci numbers");

    // Not found reports index zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_idx == '0))
        else $error("miss with nonzero index");

    // A finished result waits while the output word is still held
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !o_out.ready) |=> (r_state == ST_DONE))
        else $error("result dropped while output stalled");

endmodule

/* hdl/fibonacci_search_engine.sv */
// Flow: a write word is stored when its index lies inside the table; a search word runs its
// grow steps, then its table reads (probes and final check), and then registers its result.
// Throughput: one search at a time, set by the single registered read port of the table
// memory (one probe per cycle).
// Reset: synchronous, active low; clears the count, sequencer and output valid.
// The table is not cleared and holds undefined words until written.
`timescale 1ns / 1ps

module fibonacci_search_engine #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fse_in_if.sink                          i_in,
    fse_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fse_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [fse_pkg::CNT_W-1:0]          element_count;
    logic signed [fse_pkg::DATA_W-1:0]  rdata;
    fse_pkg::t_mem_req                  mem_req;

    // Configuration register
    fse_cfg_apb u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_element_count (element_count)
    );

    // Sorted table storage
    fse_table_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_mem_req (mem_req),
        .o_rdata   (rdata)
    );

    // Search sequencer
    fse_search_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .o_out           (o_out),
        .i_element_count (element_count),
        .i_rdata         (rdata),
        .o_mem_req       (mem_req)
    );

endmodule
